// ===== rtl/mbp_pkg.sv =====
// Shared types and constants for the MSB-first bit packer.
package mbp_pkg;

  localparam int unsigned MAX_WRITE_BITS = 64;
  localparam int unsigned BYTE_BITS      = 8;

  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_FLUSH  = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [63:0] bits_value;
    logic [6:0]  bit_count;
  } in_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       last_byte;
  } out_t;

  // Completed bytes of one input item, right-aligned, first byte highest.
  typedef struct packed {
    logic [63:0] data;
    logic [2:0]  last_idx;
  } job_t;

endpackage

// ===== rtl/mbp_front.sv =====
// Front end: accepts items, tracks the partial byte and forms byte jobs.
module mbp_front (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  mbp_pkg::in_t in_data,
  output logic         job_valid,
  input  logic         job_ready,
  output mbp_pkg::job_t job
);
  import mbp_pkg::*;

  logic [6:0]  pend_bits_r, pend_bits_nxt;
  logic [2:0]  pend_cnt_r, pend_cnt_nxt;
  logic [6:0]  cnt_sat;
  logic [63:0] value_masked;
  logic [70:0] stream;
  logic [70:0] shifted;
  logic [6:0]  total;
  logic [2:0]  new_cnt;
  logic [3:0]  nbytes;
  logic [7:0]  flush_byte;
  logic        accept;

  assign in_ready = job_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cnt_sat = (in_data.bit_count > 7'(MAX_WRITE_BITS)) ? 7'(MAX_WRITE_BITS)
                                                       : in_data.bit_count;
    if (cnt_sat == 7'(MAX_WRITE_BITS)) begin
      value_masked = in_data.bits_value;
    end else begin
      value_masked = in_data.bits_value & ((64'd1 << cnt_sat) - 64'd1);
    end
    // Pending bits are the oldest, so they sit above the new ones.
    stream  = ({64'd0, pend_bits_r} << cnt_sat) | {7'd0, value_masked};
    total   = {4'd0, pend_cnt_r} + cnt_sat;
    new_cnt = total[2:0];
    nbytes  = total[6:3];
    shifted = stream >> new_cnt;
    flush_byte = {1'b0, pend_bits_r} << (4'(BYTE_BITS) - {1'b0, pend_cnt_r});

    if (in_data.mode == MODE_FLUSH) begin
      job.data      = {56'd0, flush_byte};
      job.last_idx  = 3'd0;
      job_valid     = in_valid && (pend_cnt_r != 3'd0);
      pend_bits_nxt = 7'd0;
      pend_cnt_nxt  = 3'd0;
    end else begin
      job.data      = shifted[63:0];
      job.last_idx  = 3'(nbytes - 4'd1);
      job_valid     = in_valid && (nbytes != 4'd0);
      pend_bits_nxt = stream[6:0] & ((7'd1 << new_cnt) - 7'd1);
      pend_cnt_nxt  = new_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= 7'd0;
      pend_cnt_r  <= 3'd0;
    end else if (accept) begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

endmodule

// ===== rtl/mbp_queue.sv =====
// Short job queue between the front end and the byte serializer.
module mbp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  mbp_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output mbp_pkg::job_t pop_job
);
  import mbp_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          slots_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/mbp_back.sv =====
// Back end: sends the bytes of each job out one byte per cycle while out_ready is high.
module mbp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  output logic          job_ready,
  input  mbp_pkg::job_t job,
  output logic          out_valid,
  input  logic          out_ready,
  output mbp_pkg::out_t out_data
);
  import mbp_pkg::*;

  logic [63:0] data_r;
  logic [2:0]  idx_r;
  logic        busy_r;
  logic        out_fire, job_done;

  assign out_valid          = busy_r;
  assign out_data.byte_out  = data_r[{idx_r, 3'b000} +: 8];
  assign out_data.last_byte = (idx_r == 3'd0);
  assign out_fire           = out_valid && out_ready;
  assign job_done           = out_fire && (idx_r == 3'd0);
  // The next job loads in the same cycle the last byte of the current one leaves.
  assign job_ready          = !busy_r || job_done;

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      data_r <= job.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 3'd0;
    end else if (job_valid && job_ready) begin
      busy_r <= 1'b1;
      idx_r  <= job.last_idx;
    end else if (job_done) begin
      busy_r <= 1'b0;
    end else if (out_fire) begin
      idx_r <= idx_r - 3'd1;
    end
  end

endmodule

// ===== rtl/msb_first_bit_packer.sv =====
// Top level of the MSB-first bit packer.
// A write word appends the low bit_count bits (saturated at 64) of bits_value,
// oldest bit first, to the pending partial byte; a flush word pads the partial
// byte with zeros and sends it if any bits were pending. The front end accepts
// one input word per clock while the job queue (QUEUE_DEPTH entries) has room,
// and the serializer sends one byte per clock while out_ready is high, so an
// item yields from zero to eight bytes; the one-byte output port sets the
// sustained rate. last_byte marks the final byte caused by each input word.
module msb_first_bit_packer #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mbp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output mbp_pkg::out_t out_data
);
  import mbp_pkg::*;

  job_t fq_job, qb_job;
  logic fq_valid, fq_ready, qb_valid, qb_ready;

  mbp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_job)
  );

  mbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_job   (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_job    (qb_job)
  );

  mbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job       (qb_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/mbp_checker.sv =====
// Port-level checks for the MSB-first bit packer, bound to the top level.
module mbp_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input mbp_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input mbp_pkg::out_t out_data
);
  import mbp_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("waiting input word changed or dropped");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output word changed or dropped");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready right after reset");

  // An idle output restarts only once the job from the input word that
  // produced the new bytes has been written into the queue and then loaded
  // into the serializer.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("output word with no input accepted before it");

endmodule

bind msb_first_bit_packer mbp_checker u_mbp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
